[rtl/core/ol_pkg.sv]
package ol_pkg;

	localparam int WORD_W     = 32;
	localparam int POS_W      = 4;
	localparam int REQ_W      = 3;
	localparam int STATUS_W   = 2;
	localparam int FOUND_W    = 5;
	localparam int COUNT_W    = 5;
	localparam int RES_W      = STATUS_W + FOUND_W + COUNT_W;
	localparam int IN_DATA_W  = 40;
	localparam int IN_USER_W  = 3;
	localparam int OUT_DATA_W = 16;

	// The scanner looks at this many match flags in each cycle.
	localparam int CHUNK   = 16;
	localparam int CHUNK_W = 4;

	localparam logic [REQ_W-1:0] REQ_APPEND    = 3'd0;
	localparam logic [REQ_W-1:0] REQ_INSERT    = 3'd1;
	localparam logic [REQ_W-1:0] REQ_DROP_LAST = 3'd2;
	localparam logic [REQ_W-1:0] REQ_DROP_AT   = 3'd3;
	localparam logic [REQ_W-1:0] REQ_FIND      = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

	localparam logic [FOUND_W-1:0] NO_MATCH = 5'h1f;

	// Command broadcast to every cell of the chain.
	typedef struct packed {
		logic              app;
		logic              ins;
		logic              del;
		logic              find;
		logic [POS_W-1:0]  pos;
		logic [WORD_W-1:0] value;
	} cell_cmd_t;

	typedef struct packed {
		logic               done;
		logic               hit;
		logic [FOUND_W-1:0] idx;
	} scan_res_t;

endpackage

[rtl/core/ordered_list_table_engine.sv]
// Channel  Direction  Signals                              Contents
// s        in         s_tvalid s_tready s_tdata s_tuser     one request per transaction
// m        out        m_tvalid m_tready m_tdata             one result per request
//
// Append, insert, remove-last, remove-at and unused codes may follow one another on every
// cycle while results are not held up at the output; the cell chain shifts in one step.
// A search walks the match flags in groups of sixteen up to the first hit or the end of the
// held words, and no new request is taken until it is done.
// Reset clears the count and the control state; the stored words stay undefined.
// A stalled result and one more behind it are held before the input is held off.
module ordered_list_table_engine #(
	parameter int DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// value [31:0], position [35:32], zero [39:36]
	input  logic [ol_pkg::IN_DATA_W-1:0]  s_tdata,
	// req_type [2:0]
	input  logic [ol_pkg::IN_USER_W-1:0]  s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// status [1:0], found_index [6:2], entry_count [11:7], zero [15:12]
	output logic [ol_pkg::OUT_DATA_W-1:0] m_tdata
);
	import ol_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int MW = (CW > POS_W) ? CW : POS_W;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_SCAN = 1'b1;

	logic              state_q;
	logic [CW-1:0]     count_q;
	logic              pend_q;
	logic [RES_W-1:0]  pend_data_q;
	logic              m_tvalid_q;
	logic [RES_W-1:0]  m_data_q;

	logic [REQ_W-1:0]  req;
	logic [WORD_W-1:0] value;
	logic [POS_W-1:0]  pos;
	logic              acc;
	logic              is_find;
	logic              out_free;
	logic              full;
	logic              empty;
	logic [MW-1:0]     pos_c;
	logic [MW-1:0]     cnt_c;
	logic [STATUS_W-1:0] st;
	logic [CW-1:0]     nxt;
	logic              app;
	logic              ins;
	logic              del;

	cell_cmd_t         cmd;
	scan_res_t         scan;
	logic [WORD_W-1:0] word [DEPTH];
	logic [DEPTH-1:0]  hits;

	assign req   = s_tuser[REQ_W-1:0];
	assign value = s_tdata[WORD_W-1:0];
	assign pos   = s_tdata[WORD_W+POS_W-1:WORD_W];

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == S_IDLE) && (!pend_q || out_free);
	assign acc      = s_tvalid && s_tready;
	assign is_find  = (req == REQ_FIND);

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign pos_c = MW'(pos);
	assign cnt_c = MW'(count_q);

	always_comb begin
		st  = ST_OK;
		app = 1'b0;
		ins = 1'b0;
		del = 1'b0;
		nxt = count_q;
		case (req)
			REQ_APPEND: begin
				if (full) begin
					st = ST_FULL;
				end else begin
					app = 1'b1;
					nxt = count_q + CW'(1);
				end
			end
			REQ_INSERT: begin
				if (full) begin
					st = ST_FULL;
				end else if (pos_c > cnt_c) begin
					st = ST_RANGE;
				end else begin
					ins = 1'b1;
					nxt = count_q + CW'(1);
				end
			end
			REQ_DROP_LAST: begin
				if (empty) begin
					st = ST_EMPTY;
				end else begin
					nxt = count_q - CW'(1);
				end
			end
			REQ_DROP_AT: begin
				if (empty) begin
					st = ST_EMPTY;
				end else if (pos_c >= cnt_c) begin
					st = ST_RANGE;
				end else begin
					del = 1'b1;
					nxt = count_q - CW'(1);
				end
			end
			default: ;
		endcase
	end

	assign cmd.app   = acc && app;
	assign cmd.ins   = acc && ins;
	assign cmd.del   = acc && del;
	assign cmd.find  = acc && is_find;
	assign cmd.pos   = pos;
	assign cmd.value = value;

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [WORD_W-1:0] prev_w;
		logic [WORD_W-1:0] next_w;

		if (g == 0) begin : g_first
			assign prev_w = value;
		end else begin : g_mid_lo
			assign prev_w = word[g-1];
		end

		if (g == DEPTH - 1) begin : g_last
			assign next_w = word[g];
		end else begin : g_mid_hi
			assign next_w = word[g+1];
		end

		ol_cell #(
			.IDX (g),
			.CW  (CW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.cnt       (count_q),
			.prev_word (prev_w),
			.next_word (next_w),
			.word      (word[g]),
			.hit       (hits[g])
		);
	end

	ol_scan #(
		.DEPTH (DEPTH)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.find),
		.hits   (hits),
		.cnt    (count_q),
		.res    (scan)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			pend_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (acc) begin
				count_q <= nxt;
			end

			case (state_q)
				S_IDLE: begin
					if (acc && is_find) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (scan.done) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if ((acc && !is_find) || scan.done) begin
				pend_q <= 1'b1;
			end else if (out_free) begin
				pend_q <= 1'b0;
			end

			if (pend_q && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && !is_find) begin
			pend_data_q <= {COUNT_W'(nxt), NO_MATCH, st};
		end else if (scan.done) begin
			pend_data_q <= {COUNT_W'(count_q), scan.hit ? scan.idx : NO_MATCH, ST_OK};
		end
		if (pend_q && out_free) begin
			m_data_q <= pend_data_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(OUT_DATA_W - RES_W)'(0), m_data_q};

endmodule

[rtl/core/ol_cell.sv]
module ol_cell #(
	parameter int IDX = 0,
	parameter int CW  = 5
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ol_pkg::cell_cmd_t         cmd,
	input  logic [CW-1:0]             cnt,
	input  logic [ol_pkg::WORD_W-1:0] prev_word,
	input  logic [ol_pkg::WORD_W-1:0] next_word,
	output logic [ol_pkg::WORD_W-1:0] word,
	output logic                      hit
);
	import ol_pkg::*;

	localparam logic [CW-1:0] MY_IDX = CW'(IDX);

	logic [WORD_W-1:0] word_q;
	logic              hit_q;
	logic              at_pos;
	logic              above_pos;
	logic              at_end;
	logic              live;

	assign at_pos    = (IDX == int'(cmd.pos));
	assign above_pos = (IDX > int'(cmd.pos));
	assign at_end    = (cnt == MY_IDX);
	assign live      = (MY_IDX < cnt);

	// Slots at or beyond the count may take stale words; they are never read.
	always_ff @(posedge clk) begin
		if (cmd.app && at_end) begin
			word_q <= cmd.value;
		end else if (cmd.ins) begin
			if (at_pos) begin
				word_q <= cmd.value;
			end else if (above_pos) begin
				word_q <= prev_word;
			end
		end else if (cmd.del && (at_pos || above_pos)) begin
			word_q <= next_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (cmd.find) begin
			hit_q <= live && (word_q == cmd.value);
		end
	end

	assign word = word_q;
	assign hit  = hit_q;

endmodule

[rtl/core/ol_scan.sv]
module ol_scan #(
	parameter int DEPTH = 16,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DEPTH-1:0]  hits,
	input  logic [CW-1:0]     cnt,
	output ol_pkg::scan_res_t res
);
	import ol_pkg::*;

	localparam int NCHUNK = (DEPTH + CHUNK - 1) / CHUNK;
	localparam int KW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
	localparam int LW     = KW + CHUNK_W + 1;

	logic                    busy_q;
	logic [KW-1:0]           chunk_q;
	logic [NCHUNK*CHUNK-1:0] pad;
	logic [CHUNK-1:0]        seg;
	logic [CHUNK_W-1:0]      enc;
	logic                    any;
	logic [LW-1:0]           next_base;
	logic                    stop;

	always_comb begin
		pad = '0;
		pad[DEPTH-1:0] = hits;
	end

	assign seg = pad[chunk_q*CHUNK +: CHUNK];
	assign any = |seg;

	always_comb begin
		enc = '0;
		for (int k = CHUNK - 1; k >= 0; k--) begin
			if (seg[k]) begin
				enc = CHUNK_W'(k);
			end
		end
	end

	// Flags past the count are already clear, so the walk ends at the first
	// chunk that reaches the count.
	assign next_base = (LW'(chunk_q) << CHUNK_W) + LW'(CHUNK);
	assign stop      = any || (next_base >= LW'(cnt));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			chunk_q <= '0;
		end else if (start) begin
			busy_q  <= 1'b1;
			chunk_q <= '0;
		end else if (busy_q) begin
			if (stop) begin
				busy_q <= 1'b0;
			end else begin
				chunk_q <= chunk_q + KW'(1);
			end
		end
	end

	assign res.done = busy_q && stop;
	assign res.hit  = any;
	assign res.idx  = {chunk_q[0], enc};

endmodule

[rtl/core/ol_checker.sv]
module ol_checker #(
	parameter int DEPTH = 16
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [ol_pkg::OUT_DATA_W-1:0] m_tdata
);
	import ol_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("Stalled result transaction changed or dropped.");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] == ST_FULL) |-> m_tdata[11:7] == COUNT_W'(DEPTH))
		else $error("Full status reported with a count below capacity.");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] == ST_EMPTY) |-> m_tdata[11:7] == '0)
		else $error("Empty status reported with words still held.");

	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[6:2] != NO_MATCH) |->
			(m_tdata[1:0] == ST_OK) && ((DEPTH > CHUNK) || (m_tdata[6:2] < m_tdata[11:7])))
		else $error("Match index outside the held words or with a failing status.");

endmodule

bind ordered_list_table_engine ol_checker #(.DEPTH(DEPTH)) u_ol_checker (.*);

[test/ordered_list_table_engine_test.sv]
module ordered_list_table_engine_test;

	import ol_pkg::*;

	// Request codes that the block ignores.
	localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd5;
	localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

	localparam int STALL_HOLD = 60;
	localparam int LIMIT      = 2000;

	typedef struct packed {
		logic [REQ_W-1:0]  kind;
		logic [WORD_W-1:0] value;
		logic [POS_W-1:0]  pos;
	} list_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [FOUND_W-1:0]  found;
		logic [COUNT_W-1:0]  count;
	} list_result_t;

	typedef enum {GROW, CHURN, SHRINK} drift_t;

	class list_shadow;
		localparam int SLOTS = 16;

		logic [WORD_W-1:0] words[SLOTS];
		int                held;
		list_result_t      awaited[$];
		int                mismatches;

		function new();
			held = 0;
			mismatches = 0;
		endfunction

		// Applies one accepted request to the shadow list and queues its result.
		function void note_request(list_req_t r);
			list_result_t e;
			int           i;
			e.status = ST_OK;
			e.found = NO_MATCH;
			case (r.kind)
				REQ_APPEND: begin
					if (held >= SLOTS) begin
						e.status = ST_FULL;
					end else begin
						words[held] = r.value;
						held++;
					end
				end
				REQ_INSERT: begin
					if (held >= SLOTS) begin
						e.status = ST_FULL;
					end else if (int'(r.pos) > held) begin
						e.status = ST_RANGE;
					end else begin
						for (i = held; i > int'(r.pos); i--)
							words[i] = words[i-1];
						words[r.pos] = r.value;
						held++;
					end
				end
				REQ_DROP_LAST: begin
					if (held == 0)
						e.status = ST_EMPTY;
					else
						held--;
				end
				REQ_DROP_AT: begin
					if (held == 0) begin
						e.status = ST_EMPTY;
					end else if (int'(r.pos) >= held) begin
						e.status = ST_RANGE;
					end else begin
						for (i = int'(r.pos); i + 1 < held; i++)
							words[i] = words[i+1];
						held--;
					end
				end
				REQ_FIND: begin
					for (i = 0; i < held && e.found == NO_MATCH; i++)
						if (words[i] == r.value)
							e.found = i[FOUND_W-1:0];
				end
				default: begin
				end
			endcase
			e.count = held[COUNT_W-1:0];
			awaited.push_back(e);
		endfunction

		function void check_result(list_result_t got);
			list_result_t want;
			if (awaited.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result, expected none, actual status %0d found %0d count %0d",
					$time, got.status, $signed(got.found), got.count);
				return;
			end
			want = awaited.pop_front();
			if (got.status !== want.status) begin
				mismatches++;
				$display("%0t: status mismatch, expected %0d, actual %0d",
					$time, want.status, got.status);
			end
			if (got.found !== want.found) begin
				mismatches++;
				$display("%0t: found_index mismatch, expected %0d, actual %0d",
					$time, $signed(want.found), $signed(got.found));
			end
			if (got.count !== want.count) begin
				mismatches++;
				$display("%0t: entry_count mismatch, expected %0d, actual %0d",
					$time, want.count, got.count);
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;
	logic [IN_USER_W-1:0]  s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;

	list_shadow   sb;
	list_result_t seen;
	logic         no_idle = 1'b0;
	logic         hold_request = 1'b0;
	int           hold_left = 0;
	int           no_progress = 0;

	ordered_list_table_engine #(
		.DEPTH(list_shadow::SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic list_req_t compose(logic [REQ_W-1:0] kind, logic [WORD_W-1:0] value,
			logic [POS_W-1:0] pos);
		list_req_t r;
		r.kind = kind;
		r.value = value;
		r.pos = pos;
		return r;
	endfunction

	// Small values and words already held make duplicates and search hits common.
	function automatic logic [WORD_W-1:0] pick_word();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 40)
			return 32'($urandom_range(0, 7)) - 32'd4;
		if (roll < 65 && sb.held > 0)
			return sb.words[$urandom_range(0, sb.held - 1)];
		if (roll < 70)
			return roll[0] ? 32'h8000_0000 : 32'h7fff_ffff;
		return $urandom();
	endfunction

	function automatic list_req_t make_request(drift_t mode);
		list_req_t r;
		int        roll;
		int        add_pct;
		int        cut_pct;
		int        held;
		held = sb.held;
		r.value = pick_word();
		r.pos = 4'($urandom_range(0, 15));
		case (mode)
			GROW: begin
				add_pct = 60;
				cut_pct = 10;
			end
			SHRINK: begin
				add_pct = 10;
				cut_pct = 60;
			end
			default: begin
				add_pct = 35;
				cut_pct = 35;
			end
		endcase
		roll = $urandom_range(0, 99);
		if (roll < add_pct) begin
			if ($urandom_range(0, 1)) begin
				r.kind = REQ_APPEND;
			end else begin
				r.kind = REQ_INSERT;
				if ($urandom_range(0, 99) < 85)
					r.pos = 4'($urandom_range(0, held > 15 ? 15 : held));
			end
		end else if (roll < add_pct + cut_pct) begin
			if ($urandom_range(0, 1)) begin
				r.kind = REQ_DROP_LAST;
			end else begin
				r.kind = REQ_DROP_AT;
				if (held > 0 && $urandom_range(0, 99) < 85)
					r.pos = 4'($urandom_range(0, held - 1));
			end
		end else if (roll < 97) begin
			r.kind = REQ_FIND;
		end else begin
			r.kind = 3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
		end
		return r;
	endfunction

	task automatic send_request(list_req_t r);
		while (!no_idle && $urandom_range(0, 99) < 8) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, r.pos, r.value};
		s_tuser <= r.kind;
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_request(r);
	endtask

	task automatic wait_for_drain();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (sb.awaited.size() != 0);
	endtask

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			seen.status = m_tdata[1:0];
			seen.found = m_tdata[6:2];
			seen.count = m_tdata[11:7];
			sb.check_result(seen);
		end
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left = STALL_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= no_idle || ($urandom_range(0, 99) >= 8);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			no_progress = 0;
		else
			no_progress++;
		if (no_progress >= LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		list_req_t r;
		int        useful;
		int        n;
		drift_t    mode;
		sb = new();
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= '0;
		m_tready <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty list, bounds and the two ends of the word range.
		send_request(compose(REQ_FIND, 32'd0, 4'd0));
		send_request(compose(REQ_DROP_LAST, 32'd0, 4'd0));
		send_request(compose(REQ_DROP_AT, 32'hffff_ffff, 4'd15));
		send_request(compose(REQ_INSERT, 32'd5, 4'd1));
		send_request(compose(REQ_INSERT, 32'h8000_0000, 4'd0));
		send_request(compose(REQ_APPEND, 32'h7fff_ffff, 4'd0));
		send_request(compose(REQ_INSERT, 32'hffff_ffff, 4'd2));
		send_request(compose(REQ_INSERT, 32'd0, 4'd1));
		send_request(compose(REQ_APPEND, 32'd0, 4'd15));
		send_request(compose(REQ_FIND, 32'd0, 4'd0));
		send_request(compose(REQ_FIND, 32'h7fff_ffff, 4'd0));
		send_request(compose(REQ_FIND, 32'd12345, 4'd0));
		send_request(compose(REQ_DROP_AT, 32'd0, 4'd5));
		send_request(compose(REQ_DROP_AT, 32'd0, 4'd15));
		send_request(compose(REQ_INSERT, 32'd9, 4'd15));
		send_request(compose(REQ_DROP_AT, 32'd0, 4'd0));
		send_request(compose(REQ_SPARE_LO, 32'h7fff_ffff, 4'd0));
		send_request(compose(REQ_SPARE_LO + 3'd1, 32'd0, 4'd1));
		send_request(compose(REQ_SPARE_HI, 32'hffff_ffff, 4'd15));
		send_request(compose(REQ_DROP_LAST, 32'd0, 4'd0));
		send_request(compose(REQ_FIND, 32'h8000_0000, 4'd0));
		send_request(compose(REQ_DROP_AT, 32'd0, 4'd2));

		// Phases that push the list towards full, keep it busy, and drain it.
		useful = 0;
		n = 0;
		while (useful < 400) begin
			if (n == 60)
				hold_request = 1'b1;
			if (n == 180)
				wait_for_drain();
			no_idle = (n >= 240 && n < 320);
			case ((n / 40) % 4)
				0: mode = GROW;
				2: mode = SHRINK;
				default: mode = CHURN;
			endcase
			r = make_request(mode);
			send_request(r);
			if (r.kind <= REQ_FIND)
				useful++;
			n++;
		end
		s_tvalid <= 1'b0;
		no_idle = 1'b0;

		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
